// File: sv/lfr_pkg.sv
package lfr_pkg;

  localparam int SLOT_FW = 6;
  localparam int ADDR_FW = 10;
  localparam int LEN_FW  = 5;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_POP  = 2'd1,
    CMD_ERR  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_TICKS_PER_BIT  = 2'd0,
    REG_HALF_BIT_TICKS = 2'd1,
    REG_MAX_SPACE_BITS = 2'd2,
    REG_RELEASE_TMO    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    cmd_t command;
    logic rx_level;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_valid;
    logic [3:0] frame_length;
    logic [5:0] error_flags;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    MODE_BREAK   = 3'd0,
    MODE_RELEASE = 3'd1,
    MODE_START   = 3'd2,
    MODE_BITS    = 3'd3,
    MODE_GAP     = 3'd4
  } rx_mode_t;

  typedef enum logic [1:0] {
    DESC_EMPTY = 2'd0,
    DESC_POP   = 2'd1,
    DESC_ERR   = 2'd2
  } desc_kind_t;

  typedef struct packed {
    desc_kind_t         kind;
    logic [SLOT_FW-1:0] slot;
    logic [5:0]         flags;
  } desc_t;

  typedef struct packed {
    logic               byte_we;
    logic [ADDR_FW-1:0] byte_addr;
    logic [7:0]         byte_data;
    logic               len_we;
    logic [SLOT_FW-1:0] len_slot;
    logic [LEN_FW-1:0]  len_data;
  } mem_wr_t;

  typedef struct packed {
    logic               busy;
    logic [SLOT_FW-1:0] slot;
  } bk_status_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_LEN   = 2'd1,
    BK_BYTES = 2'd2
  } bk_state_t;

  localparam logic [3:0] BREAK_LOW_BITS = 4'd10;
  localparam logic [7:0] SYNC_BYTE      = 8'h55;
  localparam logic [3:0] DATA_BITS      = 4'd8;
  localparam logic [3:0] CNT_MAX        = 4'd15;

  localparam logic [5:0] ERR_SHORT   = 6'h01;
  localparam logic [5:0] ERR_LONG    = 6'h02;
  localparam logic [5:0] ERR_START   = 6'h04;
  localparam logic [5:0] ERR_STOP    = 6'h08;
  localparam logic [5:0] ERR_SYNC    = 6'h10;
  localparam logic [5:0] ERR_OVERRUN = 6'h20;

  localparam logic [7:0]  RST_TICKS_PER_BIT  = 8'd208;
  localparam logic [7:0]  RST_HALF_BIT_TICKS = 8'd106;
  localparam logic [3:0]  RST_MAX_SPACE_BITS = 4'd8;
  localparam logic [15:0] RST_RELEASE_TMO    = 16'd255;

endpackage

// File: sv/lfr_queue.sv
module lfr_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  lfr_pkg::desc_t             push_desc,
  input  logic                       pop,
  output logic                       full,
  output logic                       empty,
  output lfr_pkg::desc_t             head_desc,
  input  logic [lfr_pkg::SLOT_FW-1:0] check_slot,
  output logic                       conflict
);
  import lfr_pkg::*;

  desc_t      ent_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic [1:0] ent_valid;

  assign full      = (count_r == 2'd2);
  assign empty     = (count_r == 2'd0);
  assign head_desc = ent_r[rptr_r];

  always_comb begin
    ent_valid[0] = full || ((count_r == 2'd1) && !rptr_r);
    ent_valid[1] = full || ((count_r == 2'd1) && rptr_r);
    conflict = 1'b0;
    for (int i = 0; i < 2; i++) begin
      if (ent_valid[i] && (ent_r[i].kind == DESC_POP) && (ent_r[i].slot == check_slot)) begin
        conflict = 1'b1;
      end
    end
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (pop) begin
        rptr_r <= !rptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= push_desc;
    end
  end

endmodule

// File: sv/lfr_front.sv
module lfr_front #(
  parameter int FRAME_SLOTS     = 8,
  parameter int MAX_FRAME_BYTES = 10,
  parameter int MIN_FRAME_BYTES = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lfr_pkg::in_item_t    in_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 q_full,
  input  logic                 q_conflict,
  input  lfr_pkg::bk_status_t  bk_status,
  output logic                 q_push,
  output lfr_pkg::desc_t       q_desc,
  output lfr_pkg::mem_wr_t     mem_wr,
  output logic [lfr_pkg::SLOT_FW-1:0] head_slot
);
  import lfr_pkg::*;

  localparam int SLOT_W = $clog2(FRAME_SLOTS);
  localparam int LEN_W  = $clog2(MAX_FRAME_BYTES + 1);
  localparam int ADDR_W = $clog2(FRAME_SLOTS * MAX_FRAME_BYTES);

  logic [7:0]  tpb_r, half_r;
  logic [3:0]  space_r;
  logic [15:0] tmo_r;

  rx_mode_t          mode_r, mode_nxt;
  logic [7:0]        timer_r, timer_nxt;
  logic [15:0]       wait_r, wait_nxt;
  logic [3:0]        low_r, low_nxt;
  logic [3:0]        bits_r, bits_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [3:0]        bytes_r, bytes_nxt;
  logic [LEN_W-1:0]  cur_len_r, cur_len_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [5:0]        sticky_r, sticky_nxt;

  logic              accept, hazard, tick_hit, level;
  logic [8:0]        timer_inc;
  logic [16:0]       wait_inc;
  logic [11:0]       gap_limit;
  logic [3:0]        low_sat;
  logic [2:0]        bit_idx;
  logic [SLOT_W-1:0] head_inc, tail_inc;

  assign head_slot = SLOT_FW'(head_r);
  assign hazard    = q_conflict || (bk_status.busy && (bk_status.slot == SLOT_FW'(head_r)));
  assign in_ready  = !q_full && !hazard;
  assign accept    = in_valid && in_ready;
  assign level     = in_data.rx_level;

  assign timer_inc = {1'b0, timer_r} + 9'd1;
  assign tick_hit  = (timer_inc >= {1'b0, tpb_r});
  assign wait_inc  = {1'b0, wait_r} + 17'd1;
  assign gap_limit = 12'(space_r) * 12'(tpb_r);
  assign low_sat   = (low_r < CNT_MAX) ? low_r + 4'd1 : low_r;
  assign bit_idx   = 3'(bits_r - 4'd1);
  assign head_inc  = (head_r == SLOT_W'(FRAME_SLOTS - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc  = (tail_r == SLOT_W'(FRAME_SLOTS - 1)) ? '0 : tail_r + 1'b1;

  always_comb begin
    mode_nxt    = mode_r;
    timer_nxt   = timer_r;
    wait_nxt    = wait_r;
    low_nxt     = low_r;
    bits_nxt    = bits_r;
    shift_nxt   = shift_r;
    bytes_nxt   = bytes_r;
    cur_len_nxt = cur_len_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    sticky_nxt  = sticky_r;
    q_push      = 1'b0;
    q_desc      = '{kind: DESC_EMPTY, slot: '0, flags: '0};
    mem_wr      = '0;

    if (accept) begin
      unique case (in_data.command)
        CMD_TICK: begin
          unique case (mode_r)
            MODE_BREAK: begin
              if (tick_hit) begin
                timer_nxt = '0;
                if (level) begin
                  low_nxt = '0;
                end else begin
                  low_nxt = low_sat;
                  if (low_sat >= BREAK_LOW_BITS) begin
                    mode_nxt = MODE_RELEASE;
                    wait_nxt = '0;
                  end
                end
              end else begin
                timer_nxt = timer_inc[7:0];
              end
            end
            MODE_RELEASE: begin
              if (!level && (wait_inc < {1'b0, tmo_r})) begin
                wait_nxt = wait_inc[15:0];
              end else begin
                bytes_nxt   = '0;
                bits_nxt    = '0;
                cur_len_nxt = '0;
                wait_nxt    = '0;
                mode_nxt    = MODE_START;
              end
            end
            MODE_START: begin
              if (level) begin
                wait_nxt = wait_inc[15:0];
              end
              if (!(level && (wait_inc < {1'b0, tmo_r}))) begin
                timer_nxt = half_r;
                bits_nxt  = '0;
                mode_nxt  = MODE_BITS;
              end
            end
            MODE_BITS: begin
              if (tick_hit) begin
                timer_nxt = '0;
                case (bits_r) inside
                  4'd0: begin
                    if (level) begin
                      sticky_nxt = sticky_r | ((bytes_r == 4'd0) ? ERR_SYNC : ERR_START);
                      mode_nxt   = MODE_BREAK;
                      low_nxt    = '0;
                    end else begin
                      bits_nxt  = 4'd1;
                      shift_nxt = '0;
                    end
                  end
                  [4'd1:DATA_BITS]: begin
                    shift_nxt[bit_idx] = level;
                    bits_nxt = bits_r + 4'd1;
                  end
                  default: begin
                    bits_nxt = '0;
                    if (!level) begin
                      sticky_nxt = sticky_r | ((bytes_r == 4'd0) ? ERR_SYNC : ERR_STOP);
                      mode_nxt   = MODE_BREAK;
                      low_nxt    = '0;
                    end else if ((bytes_r == 4'd0) && (shift_r != SYNC_BYTE)) begin
                      sticky_nxt = sticky_r | ERR_SYNC;
                      mode_nxt   = MODE_BREAK;
                      low_nxt    = '0;
                    end else begin
                      if ((bytes_r != 4'd0) && (cur_len_r < LEN_W'(MAX_FRAME_BYTES))) begin
                        mem_wr.byte_we   = 1'b1;
                        mem_wr.byte_addr = ADDR_FW'(ADDR_W'(head_r) * ADDR_W'(MAX_FRAME_BYTES)
                                                    + ADDR_W'(cur_len_r));
                        mem_wr.byte_data = shift_r;
                        cur_len_nxt      = cur_len_r + 1'b1;
                      end
                      if (bytes_r < CNT_MAX) begin
                        bytes_nxt = bytes_r + 4'd1;
                      end
                      wait_nxt = '0;
                      mode_nxt = MODE_GAP;
                    end
                  end
                endcase
              end else begin
                timer_nxt = timer_inc[7:0];
              end
            end
            MODE_GAP: begin
              if (level) begin
                wait_nxt = wait_inc[15:0];
                if (wait_inc >= 17'(gap_limit)) begin
                  mode_nxt = MODE_BREAK;
                  low_nxt  = '0;
                  if (bytes_r < 4'(MIN_FRAME_BYTES)) begin
                    sticky_nxt = sticky_r | ERR_SHORT;
                  end else begin
                    mem_wr.len_we   = 1'b1;
                    mem_wr.len_slot = SLOT_FW'(head_r);
                    mem_wr.len_data = LEN_FW'(cur_len_r);
                    head_nxt        = head_inc;
                    if (head_inc == tail_r) begin
                      sticky_nxt = sticky_r | ERR_OVERRUN;
                      tail_nxt   = tail_inc;
                    end
                  end
                end
              end else if (cur_len_r >= LEN_W'(MAX_FRAME_BYTES)) begin
                sticky_nxt = sticky_r | ERR_LONG;
                mode_nxt   = MODE_BREAK;
                low_nxt    = '0;
              end else begin
                timer_nxt = half_r;
                bits_nxt  = '0;
                mode_nxt  = MODE_BITS;
              end
            end
            default: begin
              mode_nxt = MODE_BREAK;
              low_nxt  = '0;
            end
          endcase
        end
        CMD_POP: begin
          q_push = 1'b1;
          if (tail_r != head_r) begin
            q_desc.kind = DESC_POP;
            q_desc.slot = SLOT_FW'(tail_r);
            tail_nxt    = tail_inc;
          end
        end
        CMD_ERR: begin
          q_push       = 1'b1;
          q_desc.kind  = DESC_ERR;
          q_desc.flags = sticky_r;
          sticky_nxt   = '0;
        end
        CMD_NONE: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpb_r   <= RST_TICKS_PER_BIT;
      half_r  <= RST_HALF_BIT_TICKS;
      space_r <= RST_MAX_SPACE_BITS;
      tmo_r   <= RST_RELEASE_TMO;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TICKS_PER_BIT:  tpb_r   <= cfg_data[7:0];
        REG_HALF_BIT_TICKS: half_r  <= cfg_data[7:0];
        REG_MAX_SPACE_BITS: space_r <= cfg_data[3:0];
        REG_RELEASE_TMO:    tmo_r   <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_BREAK;
      timer_r   <= '0;
      wait_r    <= '0;
      low_r     <= '0;
      bits_r    <= '0;
      shift_r   <= '0;
      bytes_r   <= '0;
      cur_len_r <= '0;
      head_r    <= '0;
      tail_r    <= '0;
      sticky_r  <= '0;
    end else begin
      mode_r    <= mode_nxt;
      timer_r   <= timer_nxt;
      wait_r    <= wait_nxt;
      low_r     <= low_nxt;
      bits_r    <= bits_nxt;
      shift_r   <= shift_nxt;
      bytes_r   <= bytes_nxt;
      cur_len_r <= cur_len_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      sticky_r  <= sticky_nxt;
    end
  end

endmodule

// File: sv/lfr_back.sv
module lfr_back #(
  parameter int FRAME_SLOTS     = 8,
  parameter int MAX_FRAME_BYTES = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lfr_pkg::mem_wr_t    mem_wr,
  input  logic                q_empty,
  input  lfr_pkg::desc_t      q_head,
  output logic                q_pop,
  output lfr_pkg::bk_status_t bk_status,
  output logic                out_valid,
  input  logic                out_ready,
  output lfr_pkg::out_item_t  out_data
);
  import lfr_pkg::*;

  localparam int SLOT_W = $clog2(FRAME_SLOTS);
  localparam int LEN_W  = $clog2(MAX_FRAME_BYTES + 1);
  localparam int ADDR_W = $clog2(FRAME_SLOTS * MAX_FRAME_BYTES);
  localparam int DEPTH  = FRAME_SLOTS * MAX_FRAME_BYTES;

  logic [7:0]       byte_mem [DEPTH];
  logic [LEN_W-1:0] len_mem  [FRAME_SLOTS];

  bk_state_t         state_r, state_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [LEN_W-1:0]  idx_r, idx_nxt;
  logic [LEN_W-1:0]  len_q_r;
  logic [7:0]        mem_q_r;
  logic              rd_valid_r, rd_valid_nxt;
  out_item_t         rd_item_r;
  logic              rd_use_mem_r;
  logic              out_valid_r;
  out_item_t         out_item_r;

  logic              rd_take, rd_free, emit, emit_mem, byte_rd_en, len_rd_en, is_last;
  out_item_t         emit_item;
  logic [ADDR_W-1:0] rd_addr;

  assign rd_take   = rd_valid_r && (!out_valid_r || out_ready);
  assign rd_free   = !rd_valid_r || rd_take;
  assign rd_addr   = ADDR_W'(slot_r) * ADDR_W'(MAX_FRAME_BYTES) + ADDR_W'(idx_r);
  assign is_last   = (LEN_W'(idx_r + 1'b1) == len_q_r);
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;
  assign bk_status = '{busy: (state_r != BK_IDLE), slot: SLOT_FW'(slot_r)};

  always_comb begin
    state_nxt  = state_r;
    slot_nxt   = slot_r;
    idx_nxt    = idx_r;
    q_pop      = 1'b0;
    emit       = 1'b0;
    emit_mem   = 1'b0;
    byte_rd_en = 1'b0;
    len_rd_en  = 1'b0;
    emit_item  = '0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          case (q_head.kind)
            DESC_POP: begin
              q_pop     = 1'b1;
              len_rd_en = 1'b1;
              slot_nxt  = q_head.slot[SLOT_W-1:0];
              state_nxt = BK_LEN;
            end
            DESC_ERR: begin
              if (rd_free) begin
                q_pop                 = 1'b1;
                emit                  = 1'b1;
                emit_item.error_flags = q_head.flags;
                emit_item.last        = 1'b1;
              end
            end
            default: begin
              if (rd_free) begin
                q_pop          = 1'b1;
                emit           = 1'b1;
                emit_item.last = 1'b1;
              end
            end
          endcase
        end
      end
      BK_LEN: begin
        if (len_q_r == '0) begin
          if (rd_free) begin
            emit                  = 1'b1;
            emit_item.frame_valid = 1'b1;
            emit_item.last        = 1'b1;
            state_nxt             = BK_IDLE;
          end
        end else begin
          idx_nxt   = '0;
          state_nxt = BK_BYTES;
        end
      end
      BK_BYTES: begin
        if (rd_free) begin
          emit                   = 1'b1;
          emit_mem               = 1'b1;
          byte_rd_en             = 1'b1;
          emit_item.frame_valid  = 1'b1;
          emit_item.frame_length = 4'(len_q_r);
          emit_item.last         = is_last;
          idx_nxt                = idx_r + 1'b1;
          if (is_last) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
    rd_valid_nxt = emit ? 1'b1 : (rd_take ? 1'b0 : rd_valid_r);
  end

  always_ff @(posedge clk) begin
    if (mem_wr.byte_we) begin
      byte_mem[mem_wr.byte_addr[ADDR_W-1:0]] <= mem_wr.byte_data;
    end
    if (mem_wr.len_we) begin
      len_mem[mem_wr.len_slot[SLOT_W-1:0]] <= mem_wr.len_data[LEN_W-1:0];
    end
    if (byte_rd_en) begin
      mem_q_r <= byte_mem[rd_addr];
    end
    if (len_rd_en) begin
      len_q_r <= len_mem[q_head.slot[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rd_item_r    <= emit_item;
      rd_use_mem_r <= emit_mem;
    end
    if (rd_take) begin
      out_item_r           <= rd_item_r;
      out_item_r.data_byte <= rd_use_mem_r ? mem_q_r : 8'd0;
    end
    slot_r <= slot_nxt;
    idx_r  <= idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_valid_r <= rd_valid_nxt;
      if (rd_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// File: sv/lin_frame_receiver.sv
// Sample ticks are taken one per cycle unless stalled; a tick gives no output transfer.
// An error read passes through the command queue, read stage and output register; a pop
// also reads the frame length first, then gives one byte per cycle while out_ready allows.
// Input stalls while the queue is full or the filling slot is still queued or being read out.
// Synchronous active-low reset clears control state and loads the register defaults;
// frame memories are not cleared.
module lin_frame_receiver #(
  parameter int FRAME_SLOTS     = 8,
  parameter int MAX_FRAME_BYTES = 10,
  parameter int MIN_FRAME_BYTES = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lfr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lfr_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import lfr_pkg::*;

  logic               q_push, q_pop, q_full, q_empty, q_conflict;
  desc_t              q_desc, q_head;
  mem_wr_t            mem_wr;
  bk_status_t         bk_status;
  logic [SLOT_FW-1:0] head_slot;

  lfr_front #(
    .FRAME_SLOTS     (FRAME_SLOTS),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .MIN_FRAME_BYTES (MIN_FRAME_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .q_conflict (q_conflict),
    .bk_status  (bk_status),
    .q_push     (q_push),
    .q_desc     (q_desc),
    .mem_wr     (mem_wr),
    .head_slot  (head_slot)
  );

  lfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_desc  (q_desc),
    .pop        (q_pop),
    .full       (q_full),
    .empty      (q_empty),
    .head_desc  (q_head),
    .check_slot (head_slot),
    .conflict   (q_conflict)
  );

  lfr_back #(
    .FRAME_SLOTS     (FRAME_SLOTS),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mem_wr    (mem_wr),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .bk_status (bk_status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
